// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both forms are clocked and are disabled
// while the asynchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/mbuep_pkg.sv =====
package mbuep_pkg;

	localparam int MAX_CABLES_DEF = 16;
	localparam int CABLE_W        = 4;
	localparam int CNT_W          = 5;

	localparam logic [4:0] CABLE_COUNT_RST = 5'd1;

	localparam logic [7:0] STATUS_MIN = 8'h80;
	localparam logic [7:0] RT_MIN     = 8'hF8;
	localparam logic [7:0] SYSEX_BEG  = 8'hF0;
	localparam logic [7:0] SYSEX_END  = 8'hF7;
	localparam logic [3:0] NIBBLE_PGM = 4'hC;
	localparam logic [3:0] NIBBLE_CHP = 4'hD;

	localparam logic [3:0] CIN_NONE       = 4'h0;
	localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
	localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
	localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
	localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;
	localparam logic [3:0] CIN_SINGLE     = 4'hF;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_CHAN    = 2'd1,
		MODE_SYSEX   = 2'd2,
		MODE_DISCARD = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		OUT_OK         = 2'd0,
		OUT_INCOMPLETE = 2'd1,
		OUT_BAD_CABLE  = 2'd2,
		OUT_NO_END     = 2'd3
	} outcome_t;

	typedef struct packed {
		logic [3:0] cable;
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [3:0] cable_number;
		logic [3:0] code_index;
		logic [7:0] midi_first;
		logic [7:0] midi_second;
		logic [7:0] midi_third;
		outcome_t   outcome;
	} result_t;

endpackage

// ===== hw/rtl/mbuep_in_stage.sv =====
module mbuep_in_stage
	import mbuep_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t in_item,
	input  logic  take,
	output logic  valid_s1,
	output item_t item_s1
);

	logic load;

	// The stage accepts a new byte whenever it is empty or its byte leaves now.
	assign in_stall = valid_s1 && !take;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== hw/rtl/mbuep_parser.sv =====
module mbuep_parser
	import mbuep_pkg::*;
#(
	parameter int MAX_CABLES = MAX_CABLES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  item_t            item,
	input  logic [CNT_W-1:0] cable_count,
	output logic             has_result,
	output result_t          result
);

	localparam logic [CNT_W-1:0] MaxCab = CNT_W'(MAX_CABLES);

	mode_t      mode_q, mode_n;
	logic [7:0] status_q, status_n;
	logic [1:0] count_q, count_n;
	logic       one_data_q, one_data_n;
	logic [7:0] held0_q, held1_q;
	logic       h0_we, h1_we;
	logic       cab_ok;
	logic [7:0] b;

	assign b      = item.data_byte;
	assign cab_ok = ({1'b0, item.cable} < cable_count) && ({1'b0, item.cable} < MaxCab);

	always_comb begin
		mode_n     = mode_q;
		status_n   = status_q;
		count_n    = count_q;
		one_data_n = one_data_q;
		h0_we      = 1'b0;
		h1_we      = 1'b0;
		has_result = 1'b0;
		result     = '{cable_number: item.cable, code_index: CIN_NONE,
			midi_first: 8'h00, midi_second: 8'h00, midi_third: 8'h00, outcome: OUT_OK};
		if (fire) begin
			if (mode_q == MODE_DISCARD) begin
				if (item.last_byte) begin
					mode_n  = MODE_IDLE;
					count_n = 2'd0;
				end
			end else if (!cab_ok) begin
				// A bad cable drops the held message and skips the rest of the buffer.
				has_result     = 1'b1;
				result.outcome = OUT_BAD_CABLE;
				mode_n         = item.last_byte ? MODE_IDLE : MODE_DISCARD;
				count_n        = 2'd0;
			end else begin
				case (mode_q)
					MODE_CHAN: begin
						if (one_data_q) begin
							has_result         = 1'b1;
							result.code_index  = status_q[7:4];
							result.midi_first  = status_q;
							result.midi_second = b;
							mode_n             = MODE_IDLE;
							count_n            = 2'd0;
						end else if (count_q != 2'd0) begin
							has_result         = 1'b1;
							result.code_index  = status_q[7:4];
							result.midi_first  = status_q;
							result.midi_second = held0_q;
							result.midi_third  = b;
							mode_n             = MODE_IDLE;
							count_n            = 2'd0;
						end else begin
							h0_we   = 1'b1;
							count_n = 2'd1;
							if (item.last_byte) begin
								has_result     = 1'b1;
								result.outcome = OUT_INCOMPLETE;
								mode_n         = MODE_IDLE;
								count_n        = 2'd0;
							end
						end
					end
					MODE_SYSEX: begin
						if (b == SYSEX_END) begin
							has_result = 1'b1;
							mode_n     = MODE_IDLE;
							count_n    = 2'd0;
							case (count_q)
								2'd0: begin
									result.code_index = CIN_SYSEX_END1;
									result.midi_first = b;
								end
								2'd1: begin
									result.code_index  = CIN_SYSEX_END2;
									result.midi_first  = held0_q;
									result.midi_second = b;
								end
								default: begin
									result.code_index  = CIN_SYSEX_END3;
									result.midi_first  = held0_q;
									result.midi_second = held1_q;
									result.midi_third  = b;
								end
							endcase
						end else if (item.last_byte) begin
							has_result     = 1'b1;
							result.outcome = OUT_NO_END;
							mode_n         = MODE_IDLE;
							count_n        = 2'd0;
						end else if (count_q[1]) begin
							has_result         = 1'b1;
							result.code_index  = CIN_SYSEX_CONT;
							result.midi_first  = held0_q;
							result.midi_second = held1_q;
							result.midi_third  = b;
							count_n            = 2'd0;
						end else begin
							h0_we   = !count_q[0];
							h1_we   = count_q[0];
							count_n = count_q + 2'd1;
						end
					end
					default: begin
						if (b < STATUS_MIN) begin
							// Running data with no status is dropped.
						end else if (b >= RT_MIN) begin
							has_result        = 1'b1;
							result.code_index = CIN_SINGLE;
							result.midi_first = b;
						end else if (b == SYSEX_BEG) begin
							if (item.last_byte) begin
								has_result     = 1'b1;
								result.outcome = OUT_NO_END;
								mode_n         = MODE_IDLE;
								count_n        = 2'd0;
							end else begin
								mode_n  = MODE_SYSEX;
								h0_we   = 1'b1;
								count_n = 2'd1;
							end
						end else if (b >= SYSEX_BEG) begin
							// System common bytes are not forwarded.
						end else if (item.last_byte) begin
							has_result     = 1'b1;
							result.outcome = OUT_INCOMPLETE;
							mode_n         = MODE_IDLE;
							count_n        = 2'd0;
						end else begin
							mode_n     = MODE_CHAN;
							status_n   = b;
							count_n    = 2'd0;
							one_data_n = (b[7:4] == NIBBLE_PGM) || (b[7:4] == NIBBLE_CHP);
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			status_q   <= 8'h00;
			count_q    <= 2'd0;
			one_data_q <= 1'b0;
		end else begin
			mode_q     <= mode_n;
			status_q   <= status_n;
			count_q    <= count_n;
			one_data_q <= one_data_n;
		end
	end

	always_ff @(posedge clk) begin
		if (h0_we) begin
			held0_q <= b;
		end
		if (h1_we) begin
			held1_q <= b;
		end
	end

endmodule

// ===== hw/rtl/midi_bytes_to_usb_event_packets_top.sv =====
// Converts a MIDI byte stream into USB-MIDI 1.0 event packets. Each transfer on the
// input carries one byte, its cable number and an end-of-buffer mark; each transfer on
// the output carries one four-byte event packet or an error outcome. Each byte is
// held in an input register, decoded by the parser against its running state, and
// any resulting packet lands in an output register, so bytes can stream in every
// cycle while the output is not stalled. Input is stalled only while the output
// register is full and stalled itself. The cable_count register resets to one
// cable and is written through cfg_we and cfg_wdata.
`include "assert_macros.svh"

module midi_bytes_to_usb_event_packets_top
	import mbuep_pkg::*;
#(
	parameter int MAX_CABLES = MAX_CABLES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [3:0]       cable,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [3:0]       cable_number,
	output logic [3:0]       code_index,
	output logic [7:0]       midi_first,
	output logic [7:0]       midi_second,
	output logic [7:0]       midi_third,
	output logic [1:0]       outcome
);

	logic [CNT_W-1:0] cable_count_q;
	item_t            in_item;
	item_t            item_s1;
	logic             valid_s1;
	logic             fire;
	logic             has_result;
	result_t          result;
	result_t          result_q;
	logic             out_valid_q;

	assign in_item = '{cable: cable, data_byte: data_byte, last_byte: last_byte};

	// The held byte is processed unless the output register is full and blocked.
	assign fire = valid_s1 && !(out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cable_count_q <= CABLE_COUNT_RST;
		end else if (cfg_we) begin
			cable_count_q <= cfg_wdata;
		end
	end

	mbuep_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.take     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mbuep_parser #(
		.MAX_CABLES (MAX_CABLES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.cable_count (cable_count_q),
		.has_result  (has_result),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result) begin
			result_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign cable_number = result_q.cable_number;
	assign code_index   = result_q.code_index;
	assign midi_first   = result_q.midi_first;
	assign midi_second  = result_q.midi_second;
	assign midi_third   = result_q.midi_third;
	assign outcome      = result_q.outcome;

	`ASSERT_IMPLY(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall && valid_s1)
	`ASSERT_NEXT(a_result_loaded, clk, arst_n, fire && has_result, out_valid)
	`ASSERT_IMPLY(a_error_zeroed, clk, arst_n, out_valid && (outcome != OUT_OK),
		(code_index == CIN_NONE) && (midi_first == 8'h00) && (midi_second == 8'h00)
		&& (midi_third == 8'h00))
	`ASSERT_IMPLY(a_single_is_rt, clk, arst_n, out_valid && (code_index == CIN_SINGLE), midi_first >= RT_MIN)

endmodule
